>>> sv/bfa_pkg.sv
// Shared types, codes and defaults for the bitmap first-fit allocator.
package bfa_pkg;

    // Defaults for the top-level parameters
    localparam int BLOCK_COUNT_DEF     = 16;
    localparam int BYTES_PER_BLOCK_DEF = 4;

    // Fixed field widths
    localparam int BYTES_W   = 8;   // request_bytes
    localparam int BLK_W     = 8;   // rounded block count, up to 255
    localparam int SBLK_W    = 6;   // start_block
    localparam int IDX_MAX_W = 6;   // block index, BLOCK_COUNT up to 64
    localparam int CNT_MAX_W = 7;   // block count, up to 64
    localparam int RSTART_W  = 4;   // run_start
    localparam int RBLK_W    = 7;   // run_blocks
    localparam int AFREE_W   = 5;   // already_free
    localparam int MAP_W     = 16;  // occupancy_map

    // Request codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_RUN    = 2'd1,
        STATUS_BAD_RANGE = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_FREE,
        ST_DONE
    } seq_state_t;

    // Decoded request, held stable while the sequencer works
    typedef struct packed {
        logic                 is_free;
        logic [BLK_W-1:0]     blocks;
        logic [IDX_MAX_W-1:0] start_idx;
        logic                 zero_size;
        logic                 range_bad;
    } req_t;

    // Completion report from the sequencer
    typedef struct packed {
        logic                 fin;
        status_t              status;
        logic [IDX_MAX_W-1:0] cand;
        logic [CNT_MAX_W-1:0] already;
    } res_t;

    // Bitmap write port
    typedef struct packed {
        logic                 en;
        logic [IDX_MAX_W-1:0] addr;
        logic                 data;
    } ram_wr_t;

endpackage

>>> sv/bfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bfa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

>>> sv/bfa_seq.sv
// Sequencer: clear pass, first-fit scan, run marking and run freeing over the bitmap RAM.
module bfa_seq
    import bfa_pkg::*;
#(
    parameter int BLOCK_COUNT = BLOCK_COUNT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           go,
    input  req_t                           req,
    input  logic                           rd_data,
    output logic [$clog2(BLOCK_COUNT)-1:0] rd_addr,
    output ram_wr_t                        wr,
    output res_t                           res,
    output logic                           busy
);

    localparam int IW = $clog2(BLOCK_COUNT);
    localparam int CW = $clog2(BLOCK_COUNT + 1);

    seq_state_t    state_reg, state_next;
    logic [CW-1:0] addr_reg, addr_next;     // next address to read or write
    logic          pend_reg, pend_next;     // read data arrives this cycle
    logic [IW-1:0] pidx_reg, pidx_next;     // index of the arriving read data
    logic [CW-1:0] cnt_reg, cnt_next;       // current free run length
    logic [IW-1:0] cand_reg, cand_next;     // start of the current free run
    logic [CW-1:0] left_reg, left_next;     // blocks left to mark or to read
    logic [CW-1:0] afree_reg, afree_next;   // blocks found already free
    status_t       status_reg, status_next;

    logic [BLK_W-1:0] run_len;
    logic             run_hit;

    // Run length including the block now arriving
    assign run_len = BLK_W'(cnt_reg) + BLK_W'(1);
    assign run_hit = (run_len == req.blocks);

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            addr_reg   <= '0;
            pend_reg   <= 1'b0;
            pidx_reg   <= '0;
            cnt_reg    <= '0;
            cand_reg   <= '0;
            left_reg   <= '0;
            afree_reg  <= '0;
            status_reg <= STATUS_OK;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            pend_reg   <= pend_next;
            pidx_reg   <= pidx_next;
            cnt_reg    <= cnt_next;
            cand_reg   <= cand_next;
            left_reg   <= left_next;
            afree_reg  <= afree_next;
            status_reg <= status_next;
        end
    end

    // Next state and RAM control
    always_comb
    begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        pend_next   = 1'b0;
        pidx_next   = pidx_reg;
        cnt_next    = cnt_reg;
        cand_next   = cand_reg;
        left_next   = left_reg;
        afree_next  = afree_reg;
        status_next = status_reg;
        rd_addr     = addr_reg[IW-1:0];
        wr.en       = 1'b0;
        wr.addr     = IDX_MAX_W'(addr_reg[IW-1:0]);
        wr.data     = 1'b0;
        res.fin     = 1'b0;
        res.status  = status_reg;
        res.cand    = IDX_MAX_W'(cand_reg);
        res.already = CNT_MAX_W'(afree_reg);

        case (state_reg)
            // Zero every entry once after reset
            ST_CLEAR:
            begin
                wr.en     = 1'b1;
                addr_next = addr_reg + CW'(1);
                if (addr_reg == CW'(BLOCK_COUNT - 1))
                begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (go)
                begin
                    cnt_next    = '0;
                    afree_next  = '0;
                    status_next = STATUS_OK;
                    if (req.is_free == ACT_FREE)
                    begin
                        addr_next = CW'(req.start_idx);
                        left_next = CW'(req.blocks);
                        if (req.range_bad)
                        begin
                            status_next = STATUS_BAD_RANGE;
                            state_next  = ST_DONE;
                        end
                        else if (req.zero_size)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_FREE;
                        end
                    end
                    else
                    begin
                        addr_next = '0;
                        if (req.zero_size)
                        begin
                            status_next = STATUS_NO_RUN;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                end
            end

            // Stream reads from block 0, track the free run on the registered read data
            ST_SCAN:
            begin
                if (addr_reg != CW'(BLOCK_COUNT))
                begin
                    addr_next = addr_reg + CW'(1);
                    pend_next = 1'b1;
                    pidx_next = addr_reg[IW-1:0];
                end
                if (pend_reg)
                begin
                    if (!rd_data)
                    begin
                        if (cnt_reg == '0)
                        begin
                            cand_next = pidx_reg;
                        end
                        cnt_next = cnt_reg + CW'(1);
                        if (run_hit)
                        begin
                            addr_next  = (cnt_reg == '0) ? CW'(pidx_reg) : CW'(cand_reg);
                            left_next  = CW'(req.blocks);
                            pend_next  = 1'b0;
                            state_next = ST_MARK;
                        end
                    end
                    else
                    begin
                        cnt_next = '0;
                    end
                    if (!(run_hit && !rd_data) && addr_reg == CW'(BLOCK_COUNT))
                    begin
                        status_next = STATUS_NO_RUN;
                        state_next  = ST_DONE;
                    end
                end
            end

            // Set one bit of the found run per cycle
            ST_MARK:
            begin
                wr.en     = 1'b1;
                wr.data   = 1'b1;
                addr_next = addr_reg + CW'(1);
                left_next = left_reg - CW'(1);
                if (left_reg == CW'(1))
                begin
                    state_next = ST_DONE;
                end
            end

            // Read each block of the range, clear it when its read data returns
            ST_FREE:
            begin
                if (left_reg != '0)
                begin
                    addr_next = addr_reg + CW'(1);
                    left_next = left_reg - CW'(1);
                    pend_next = 1'b1;
                    pidx_next = addr_reg[IW-1:0];
                end
                if (pend_reg)
                begin
                    wr.en   = 1'b1;
                    wr.addr = IDX_MAX_W'(pidx_reg);
                    if (!rd_data)
                    begin
                        afree_next = afree_reg + CW'(1);
                    end
                    if (left_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_DONE:
            begin
                res.fin    = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

>>> sv/bitmap_first_fit_allocator.sv
// Top level of the bitmap first-fit allocator: request decode, bitmap RAM, result registers.
//
//  Channel  | Handshake                    | Ports
//  ---------+------------------------------+-----------------------------------------------
//  request  | transfer when start && !busy | action, request_bytes, start_block
//  result   | done high for one cycle      | status, run_start, run_blocks, already_free,
//           |                              | occupancy_map
//
// Allocate: the first-fit scan streams one RAM read per cycle, then marks one block per
// cycle through the single RAM write port. Free: one block read and cleared per cycle.
// Zero-size requests and bad free ranges go straight to the result; an allocate
// with no fitting run ends after reading every block.
// After reset a clearing pass writes every RAM entry with busy high.
// Results cannot be held off; one item is in work at a time while busy is high.
module bitmap_first_fit_allocator
    import bfa_pkg::*;
#(
    parameter int BLOCK_COUNT     = BLOCK_COUNT_DEF,
    parameter int BYTES_PER_BLOCK = BYTES_PER_BLOCK_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                action,
    input  logic [BYTES_W-1:0]  request_bytes,
    input  logic [SBLK_W-1:0]   start_block,
    output logic                done,
    output logic [1:0]          status,
    output logic [RSTART_W-1:0] run_start,
    output logic [RBLK_W-1:0]   run_blocks,
    output logic [AFREE_W-1:0]  already_free,
    output logic [MAP_W-1:0]    occupancy_map
);

    localparam int IW    = $clog2(BLOCK_COUNT);
    localparam int SUM_W = BLK_W + 2;

    // Reciprocal of the block size: exact for sums below 1024 and block sizes up to 256
    localparam int RECIP_SH = 18;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int PROD_W   = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((2 ** RECIP_SH + BYTES_PER_BLOCK - 1) / BYTES_PER_BLOCK);

    logic              accept;
    logic              go_reg;
    logic              seq_busy;
    logic              act_reg;
    logic [BLK_W-1:0]  blocks_reg;
    logic [SBLK_W-1:0] start_reg;
    logic [SUM_W-1:0]  bytes_sum;
    logic [PROD_W-1:0] bytes_prod;
    logic [BLK_W-1:0]  blocks_calc;
    logic [MAP_W-1:0]  map_reg;
    req_t              req;
    res_t              res;
    ram_wr_t           wr;
    logic [IW-1:0]     rd_addr;
    logic              rd_data;

    assign accept = start && !busy;
    assign busy   = seq_busy || go_reg;

    // Round the byte size up to whole blocks
    assign bytes_sum   = SUM_W'(request_bytes) + SUM_W'(BYTES_PER_BLOCK - 1);
    assign bytes_prod  = PROD_W'(bytes_sum) * PROD_W'(RECIP);
    assign blocks_calc = BLK_W'(bytes_prod >> RECIP_SH);

    // Request capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            go_reg <= 1'b0;
        end
        else
        begin
            go_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg    <= action;
            blocks_reg <= blocks_calc;
            start_reg  <= start_block;
        end
    end

    // Decoded request for the sequencer
    assign req.is_free   = act_reg;
    assign req.blocks    = blocks_reg;
    assign req.start_idx = IDX_MAX_W'(start_reg);
    assign req.zero_size = (blocks_reg == '0);
    assign req.range_bad = (SUM_W'(start_reg) >= SUM_W'(BLOCK_COUNT))
                        || (SUM_W'(start_reg) + SUM_W'(blocks_reg) > SUM_W'(BLOCK_COUNT));

    bfa_seq #(
        .BLOCK_COUNT(BLOCK_COUNT)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (go_reg),
        .req     (req),
        .rd_data (rd_data),
        .rd_addr (rd_addr),
        .wr      (wr),
        .res     (res),
        .busy    (seq_busy)
    );

    bfa_ram #(
        .WIDTH(1),
        .DEPTH(BLOCK_COUNT)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (wr.en),
        .wr_addr (IW'(wr.addr)),
        .wr_data (wr.data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Copy of the low blocks of the bitmap for the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < MAP_W; k++)
            begin
                if (wr.en && (CNT_MAX_W'(wr.addr) == CNT_MAX_W'(k)))
                begin
                    map_reg[k] <= wr.data;
                end
            end
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= res.fin;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (res.fin)
        begin
            status        <= res.status;
            occupancy_map <= map_reg;
            run_blocks    <= (blocks_reg > BLK_W'(127)) ? RBLK_W'(127) : RBLK_W'(blocks_reg);
            already_free  <= (res.already > CNT_MAX_W'(31)) ? AFREE_W'(31)
                                                            : AFREE_W'(res.already);
            if (act_reg == ACT_FREE)
            begin
                run_start <= RSTART_W'(start_reg);
            end
            else if (res.status == STATUS_OK)
            begin
                run_start <= RSTART_W'(res.cand);
            end
            else
            begin
                run_start <= '0;
            end
        end
    end

endmodule

>>> test/tb.sv
// Self-checking testbench for the bitmap first-fit allocator: predictor, scoreboard, stimulus.
module tb
    import bfa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBLK = BLOCK_COUNT_DEF;
    localparam int BPB  = BYTES_PER_BLOCK_DEF;

    // One result transfer as the block reports it
    typedef struct {
        status_t             status;
        logic [RSTART_W-1:0] run_start;
        logic [RBLK_W-1:0]   run_blocks;
        logic [AFREE_W-1:0]  already_free;
        logic [MAP_W-1:0]    occupancy_map;
    } alloc_result_t;

    // A run the stimulus believes is still allocated
    typedef struct {
        int first;
        int len;
    } live_run_t;

    // Bitmap predictor plus queue of expected results
    class alloc_scoreboard;
        logic [NBLK-1:0] block_map;
        alloc_result_t   expected_q[$];
        int              errors;

        function new();
            block_map = '0;
            errors    = 0;
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        // Predict the outcome of one accepted request and queue it
        function alloc_result_t note_request(logic act, logic [BYTES_W-1:0] bytes,
                                             logic [SBLK_W-1:0] sblk);
            alloc_result_t r;
            int            blocks;
            int            count;
            int            cand;
            int            freed;
            bit            found;
            blocks         = (int'(bytes) + BPB - 1) / BPB;
            count          = 0;
            cand           = 0;
            freed          = 0;
            found          = 1'b0;
            r.status       = STATUS_OK;
            r.run_start    = '0;
            if (act == ACT_ALLOC)
            begin
                // first-fit scan from block 0
                if (blocks != 0)
                begin
                    for (int i = 0; i < NBLK; i++)
                    begin
                        if (!block_map[i])
                        begin
                            if (count == 0)
                                cand = i;
                            count++;
                            if (count == blocks)
                            begin
                                found = 1'b1;
                                break;
                            end
                        end
                        else
                            count = 0;
                    end
                end
                if (found)
                begin
                    for (int i = cand; i < cand + blocks; i++)
                        block_map[i] = 1'b1;
                    r.run_start = RSTART_W'(cand);
                end
                else
                    r.status = STATUS_NO_RUN;
            end
            else
            begin
                r.run_start = RSTART_W'(sblk);
                if (int'(sblk) >= NBLK || int'(sblk) + blocks > NBLK)
                    r.status = STATUS_BAD_RANGE;
                else
                begin
                    for (int i = int'(sblk); i < int'(sblk) + blocks; i++)
                    begin
                        if (block_map[i])
                            block_map[i] = 1'b0;
                        else
                            freed++;
                    end
                end
            end
            r.run_blocks    = (blocks > 127) ? 7'd127 : RBLK_W'(blocks);
            r.already_free  = (freed > 31) ? 5'd31 : AFREE_W'(freed);
            r.occupancy_map = MAP_W'(block_map);
            expected_q.push_back(r);
            return r;
        endfunction

        // Compare one result transfer against the oldest expectation
        function void check_result(logic [1:0] st, logic [RSTART_W-1:0] rs,
                                   logic [RBLK_W-1:0] rb, logic [AFREE_W-1:0] af,
                                   logic [MAP_W-1:0] map);
            alloc_result_t e;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result transfer, status %0d run_start %0d map %h",
                         $time, st, rs, map);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (st !== e.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                errors++;
            end
            if (rs !== e.run_start)
            begin
                $display("%0t: run_start expected %0d actual %0d", $time, e.run_start, rs);
                errors++;
            end
            if (rb !== e.run_blocks)
            begin
                $display("%0t: run_blocks expected %0d actual %0d", $time, e.run_blocks, rb);
                errors++;
            end
            if (af !== e.already_free)
            begin
                $display("%0t: already_free expected %0d actual %0d", $time,
                         e.already_free, af);
                errors++;
            end
            if (map !== e.occupancy_map)
            begin
                $display("%0t: occupancy_map expected %h actual %h", $time,
                         e.occupancy_map, map);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                action;
    logic [BYTES_W-1:0]  request_bytes;
    logic [SBLK_W-1:0]   start_block;
    logic                done;
    logic [1:0]          status;
    logic [RSTART_W-1:0] run_start;
    logic [RBLK_W-1:0]   run_blocks;
    logic [AFREE_W-1:0]  already_free;
    logic [MAP_W-1:0]    occupancy_map;

    alloc_scoreboard sb = new();
    live_run_t       live_runs[$];

    bitmap_first_fit_allocator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .request_bytes (request_bytes),
        .start_block   (start_block),
        .done          (done),
        .status        (status),
        .run_start     (run_start),
        .run_blocks    (run_blocks),
        .already_free  (already_free),
        .occupancy_map (occupancy_map)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result monitor: the strobe is sampled at the edge that ends its cycle
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            sb.check_result(status, run_start, run_blocks, already_free, occupancy_map);
    end

    // Keep the list of allocated runs in step with the predicted outcome
    function automatic void track_live(logic act, alloc_result_t r, logic [SBLK_W-1:0] sblk,
                                       logic [BYTES_W-1:0] bytes);
        live_run_t lr;
        int        nb;
        int        lo;
        nb = (int'(bytes) + BPB - 1) / BPB;
        if (r.status != STATUS_OK || nb == 0)
            return;
        if (act == ACT_ALLOC)
        begin
            lr.first = int'(r.run_start);
            lr.len   = nb;
            live_runs.push_back(lr);
        end
        else
        begin
            lo = int'(sblk);
            for (int i = live_runs.size() - 1; i >= 0; i--)
                if (live_runs[i].first < lo + nb && live_runs[i].first + live_runs[i].len > lo)
                    live_runs.delete(i);
        end
    endfunction

    // Drive one request from a falling edge and hold it until the transfer
    task automatic transfer_request(logic act, logic [BYTES_W-1:0] bytes,
                                    logic [SBLK_W-1:0] sblk);
        alloc_result_t pred;
        start         = 1'b1;
        action        = act;
        request_bytes = bytes;
        start_block   = sblk;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pred = sb.note_request(act, bytes, sblk);
        track_live(act, pred, sblk, bytes);
        @(negedge clk);
    endtask

    // Random sender gap: mostly none or short, now and then long
    task automatic idle_gap(bit quiet);
        int r;
        int n;
        n = 0;
        r = $urandom_range(0, 99);
        if (!quiet)
        begin
            if (r >= 90)
                n = $urandom_range(10, 60);
            else if (r >= 60)
                n = $urandom_range(1, 3);
        end
        if (n > 0)
        begin
            start = 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // Hold off the sender until every expected result has come back
    task automatic drain_results();
        start = 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
    endtask

    // Mostly well-formed alloc/free traffic, some out-of-range and noise requests
    task automatic random_request();
        int                 r;
        int                 sz;
        int                 idx;
        int                 first;
        logic [BYTES_W-1:0] bytes;
        r = $urandom_range(0, 99);
        if (live_runs.size() == 0 || r < 45)
        begin
            sz = $urandom_range(0, 19);
            if (sz == 0)
                bytes = '0;
            else if (sz < 3)
                bytes = BYTES_W'($urandom_range(0, 255));
            else
                bytes = BYTES_W'($urandom_range(1, 24));
            transfer_request(ACT_ALLOC, bytes, SBLK_W'($urandom_range(0, 63)));
        end
        else if (r < 80)
        begin
            // free exactly one live run, byte count anywhere inside its last block
            idx   = $urandom_range(0, live_runs.size() - 1);
            first = live_runs[idx].first;
            bytes = BYTES_W'(live_runs[idx].len * BPB - $urandom_range(0, BPB - 1));
            transfer_request(ACT_FREE, bytes, SBLK_W'(first));
        end
        else if (r < 92)
        begin
            // in-range free that may straddle runs and holes
            first = $urandom_range(0, NBLK - 1);
            bytes = BYTES_W'($urandom_range(0, (NBLK - first) * BPB));
            transfer_request(ACT_FREE, bytes, SBLK_W'(first));
        end
        else
            transfer_request(1'($urandom_range(0, 1)), BYTES_W'($urandom_range(0, 255)),
                             SBLK_W'($urandom_range(0, 63)));
    endtask

    // Main sequence
    initial
    begin
        bit quiet;
        rst_n         = 1'b0;
        start         = 1'b0;
        action        = ACT_ALLOC;
        request_bytes = '0;
        start_block   = '0;
        quiet         = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: sizes, holes, full map, range errors, field extremes
        transfer_request(ACT_ALLOC, 8'd0,   6'd0);   // zero-size allocate fails
        transfer_request(ACT_ALLOC, 8'd1,   6'd0);   // one byte rounds up to one block
        transfer_request(ACT_ALLOC, 8'd4,   6'd0);
        transfer_request(ACT_ALLOC, 8'd5,   6'd0);   // two blocks
        transfer_request(ACT_FREE,  8'd4,   6'd1);   // open a one-block hole
        transfer_request(ACT_ALLOC, 8'd8,   6'd0);   // too big for the hole
        transfer_request(ACT_ALLOC, 8'd3,   6'd0);   // fills the hole
        transfer_request(ACT_FREE,  8'd0,   6'd0);   // zero-size free
        transfer_request(ACT_FREE,  8'd0,   6'd15);
        transfer_request(ACT_FREE,  8'd0,   6'd16);  // start past the end
        transfer_request(ACT_FREE,  8'd255, 6'd63);
        transfer_request(ACT_FREE,  8'd12,  6'd14);  // range runs past the end
        transfer_request(ACT_FREE,  8'd64,  6'd0);   // whole map, some already free
        transfer_request(ACT_FREE,  8'd64,  6'd0);   // whole map, all already free
        transfer_request(ACT_ALLOC, 8'd255, 6'd63);  // 64 blocks never fit
        transfer_request(ACT_ALLOC, 8'd68,  6'd0);   // one block too many
        transfer_request(ACT_ALLOC, 8'd64,  6'd0);   // fills the map
        transfer_request(ACT_ALLOC, 8'd1,   6'd0);   // map full
        transfer_request(ACT_FREE,  8'd32,  6'd8);
        transfer_request(ACT_ALLOC, 8'd33,  6'd0);
        transfer_request(ACT_ALLOC, 8'd32,  6'd0);
        transfer_request(ACT_FREE,  8'd64,  6'd0);
        transfer_request(ACT_FREE,  8'd4,   6'd15);  // last block, already free
        transfer_request(ACT_FREE,  8'd170, 6'd42);
        transfer_request(ACT_ALLOC, 8'd85,  6'd21);
        drain_results();

        // Random traffic in stretches, some with no sender gaps
        for (int k = 0; k < 1250; k++)
        begin
            if (k % 125 == 0)
                quiet = ($urandom_range(0, 2) == 0);
            if (k % 250 == 249)
                drain_results();
            random_request();
            idle_gap(quiet);
        end
        start = 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
sv/bfa_pkg.sv
sv/bfa_ram.sv
sv/bfa_seq.sv
sv/bitmap_first_fit_allocator.sv
test/tb.sv
